// ===== hw/rtl/flt_pkg.sv =====
package flt_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_OPEN   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_NEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_SIZE  = 3'd3,
        ST_ROW   = 3'd4,
        ST_EMPTY = 3'd5,
        ST_EOL   = 3'd6,
        ST_ACK   = 3'd7
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_ROW  = 3'b100
    } t_state;

    // One stored flow
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [31:0] hits;
        logic [31:0] stamp;
    } t_row;

    localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] HITS_ONE = 32'd1;

endpackage

// ===== hw/rtl/flt_ram.sv =====
module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/flt_upd.sv =====
module flt_upd
    import flt_pkg::*;
(
    input  t_row i_row,
    input  t_row i_key,
    output logic o_hit,
    output t_row o_upd,
    output t_row o_fresh
);

    // Match the five-tuple of the stored row against the key
    assign o_hit = (i_row.src == i_key.src) && (i_row.dst == i_key.dst) &&
                   (i_row.sport == i_key.sport) && (i_row.dport == i_key.dport) &&
                   (i_row.proto == i_key.proto);

    // Bump the hit count (saturating) and refresh the timestamp
    always_comb begin
        o_upd       = i_row;
        o_upd.hits  = (i_row.hits == HITS_MAX) ? i_row.hits : i_row.hits + HITS_ONE;
        o_upd.stamp = i_key.stamp;
    end

    // Build a new flow with a count of one
    always_comb begin
        o_fresh      = i_key;
        o_fresh.hits = HITS_ONE;
    end

endmodule

// ===== hw/rtl/flow_log_table_top.sv =====
// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+------------------------------
// command  | i_command, i_src_addr .. i_now_seconds    | taken when start & !busy
// result   | o_status, o_entry_total, o_out_*          | o_valid, one cycle, no stall
//
// A record on an empty table appends at once; otherwise the sequencer scans the
// flows until a hit or the end of the table (at most TABLE_DEPTH flows are
// compared); one comparator walks the flow RAM one row per cycle. A row read
// waits in S_ROW for the registered RAM word; other commands answer from idle.
// The result strobes in the cycle after the last working cycle.
// Reset is synchronous and clears the counters and the sequencer; the flow RAM
// is not cleared, only rows below the entry count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module flow_log_table_top
    import flt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port_in,
    input  logic [15:0] i_dst_port_in,
    input  logic [7:0]  i_proto_in,
    input  logic [31:0] i_now_seconds,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [6:0]  o_entry_total,
    output logic [31:0] o_out_src_addr,
    output logic [31:0] o_out_dst_addr,
    output logic [15:0] o_out_src_port,
    output logic [15:0] o_out_dst_port,
    output logic [7:0]  o_out_proto,
    output logic [31:0] o_out_hits,
    output logic [31:0] o_out_time
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Control state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_used, n_used;
    logic [CW-1:0]  r_cursor, n_cursor;
    logic           r_sent, n_sent;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_valid, n_valid;

    // Payload
    t_row           r_key, n_key;
    t_status        r_status, n_status;
    logic [6:0]     r_total, n_total;
    t_row           r_orow, n_orow;

    // RAM and compare unit
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    t_row           ram_wdata;
    t_row           ram_q;
    t_row           key_in;
    t_row           cmp_key;
    logic           cmp_hit;
    t_row           cmp_upd;
    t_row           cmp_fresh;
    logic [CW+6:0]  total_ext;
    logic [CW-1:0]  idx_inc;

    assign busy = (r_state != S_IDLE);

    // Pack the incoming key
    always_comb begin
        key_in.src   = i_src_addr;
        key_in.dst   = i_dst_addr;
        key_in.sport = i_src_port_in;
        key_in.dport = i_dst_port_in;
        key_in.proto = i_proto_in;
        key_in.hits  = '0;
        key_in.stamp = i_now_seconds;
    end

    assign cmp_key   = (r_state == S_IDLE) ? key_in : r_key;
    assign total_ext = {7'd0, r_used};
    assign idx_inc   = r_idx + ONE_C;

    flt_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    flt_upd u_upd (
        .i_row   (ram_q),
        .i_key   (cmp_key),
        .o_hit   (cmp_hit),
        .o_upd   (cmp_upd),
        .o_fresh (cmp_fresh)
    );

    // Sequence commands
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_cursor  = r_cursor;
        n_sent    = r_sent;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_key     = r_key;
        n_status  = r_status;
        n_total   = '0;
        n_orow    = '0;
        ram_we    = 1'b0;
        ram_waddr = r_used[AW-1:0];
        ram_wdata = cmp_fresh;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = key_in;
                    case (t_cmd'(i_command))
                        CMD_RECORD: begin
                            if (r_used == '0) begin
                                // Empty table: append at once
                                ram_we   = 1'b1;
                                n_used   = r_used + ONE_C;
                                n_valid  = 1'b1;
                                n_status = ST_NEW;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_OPEN: begin
                            n_sent   = 1'b0;
                            n_cursor = '0;
                            n_valid  = 1'b1;
                            n_status = ST_ACK;
                        end
                        CMD_READ: begin
                            if (!r_sent) begin
                                n_sent   = 1'b1;
                                n_cursor = '0;
                                n_valid  = 1'b1;
                                n_status = ST_SIZE;
                                n_total  = total_ext[6:0];
                            end else if (r_used == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (r_cursor >= r_used) begin
                                n_valid  = 1'b1;
                                n_status = ST_EOL;
                            end else begin
                                n_idx   = r_cursor;
                                n_state = S_ROW;
                            end
                        end
                        CMD_CLEAR: begin
                            n_used   = '0;
                            n_cursor = '0;
                            n_sent   = 1'b0;
                            n_valid  = 1'b1;
                            n_status = ST_ACK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (cmp_hit) begin
                    // Update the matching flow in place
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = cmp_upd;
                    n_valid   = 1'b1;
                    n_status  = ST_HIT;
                    n_state   = S_IDLE;
                end else if (idx_inc == r_used) begin
                    // Last row missed: append or drop
                    if (r_used == DEPTH_C) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        n_used   = r_used + ONE_C;
                        n_status = ST_NEW;
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_ROW: begin
                n_valid  = 1'b1;
                n_status = ST_ROW;
                n_orow   = ram_q;
                n_cursor = r_cursor + ONE_C;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_cursor <= '0;
            r_sent   <= 1'b0;
            r_idx    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cursor <= n_cursor;
            r_sent   <= n_sent;
            r_idx    <= n_idx;
            r_valid  <= n_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_status <= n_status;
        r_total  <= n_total;
        r_orow   <= n_orow;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_entry_total  = r_total;
    assign o_out_src_addr = r_orow.src;
    assign o_out_dst_addr = r_orow.dst;
    assign o_out_src_port = r_orow.sport;
    assign o_out_dst_port = r_orow.dport;
    assign o_out_proto    = r_orow.proto;
    assign o_out_hits     = r_orow.hits;
    assign o_out_time     = r_orow.stamp;

endmodule

// ===== dv/flow_log_table_top_tb.sv =====
`timescale 1ns / 100ps

module flow_log_table_top_tb;
    import flt_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 560;
    localparam int POOL_MAX     = 96;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

    // One command item as driven on the ports
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [31:0] now;
    } t_item;

    // One predicted reply
    typedef struct packed {
        t_status     status;
        logic [6:0]  total;
        t_row        row;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [15:0] i_src_port_in;
    logic [15:0] i_dst_port_in;
    logic [7:0]  i_proto_in;
    logic [31:0] i_now_seconds;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [6:0]  o_entry_total;
    logic [31:0] o_out_src_addr;
    logic [31:0] o_out_dst_addr;
    logic [15:0] o_out_src_port;
    logic [15:0] o_out_dst_port;
    logic [7:0]  o_out_proto;
    logic [31:0] o_out_hits;
    logic [31:0] o_out_time;

    // Shadow copy of the flow table and reader
    t_row   flow_rows [TABLE_DEPTH];
    int     held_count;
    int     read_pos;
    bit     size_done;

    t_reply expected_replies [$];
    t_row   flow_pool [$];

    int     error_count;
    int     items_sent;
    int     replies_checked;
    int     status_seen [8];
    int     burst_left;
    bit     gaps_on;

    flow_log_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_src_addr     (i_src_addr),
        .i_dst_addr     (i_dst_addr),
        .i_src_port_in  (i_src_port_in),
        .i_dst_port_in  (i_dst_port_in),
        .i_proto_in     (i_proto_in),
        .i_now_seconds  (i_now_seconds),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_entry_total  (o_entry_total),
        .o_out_src_addr (o_out_src_addr),
        .o_out_dst_addr (o_out_dst_addr),
        .o_out_src_port (o_out_src_port),
        .o_out_dst_port (o_out_dst_port),
        .o_out_proto    (o_out_proto),
        .o_out_hits     (o_out_hits),
        .o_out_time     (o_out_time)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Work out the reply to one item and advance the shadow table
    function automatic t_reply predict_flow_table(t_item it);
        t_reply r;
        int     hit_idx;
        r = '0;
        hit_idx = -1;
        case (it.cmd)
            CMD_RECORD: begin
                for (int k = 0; k < held_count; k++) begin
                    if (hit_idx < 0 && flow_rows[k].src == it.src && flow_rows[k].dst == it.dst
                        && flow_rows[k].sport == it.sport && flow_rows[k].dport == it.dport
                        && flow_rows[k].proto == it.proto) begin
                        hit_idx = k;
                    end
                end
                if (hit_idx >= 0) begin
                    if (flow_rows[hit_idx].hits != HITS_MAX) begin
                        flow_rows[hit_idx].hits = flow_rows[hit_idx].hits + 1;
                    end
                    flow_rows[hit_idx].stamp = it.now;
                    r.status = ST_HIT;
                end else if (held_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    flow_rows[held_count] = '{it.src, it.dst, it.sport, it.dport, it.proto,
                                              HITS_ONE, it.now};
                    held_count++;
                    r.status = ST_NEW;
                end
            end
            CMD_OPEN: begin
                size_done = 1'b0;
                read_pos = 0;
                r.status = ST_ACK;
            end
            CMD_READ: begin
                if (!size_done) begin
                    size_done = 1'b1;
                    read_pos = 0;
                    r.status = ST_SIZE;
                    r.total = held_count[6:0];
                end else if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (read_pos >= held_count) begin
                    r.status = ST_EOL;
                end else begin
                    r.status = ST_ROW;
                    r.row = flow_rows[read_pos];
                    read_pos++;
                end
            end
            default: begin
                held_count = 0;
                read_pos = 0;
                size_done = 1'b0;
                r.status = ST_ACK;
            end
        endcase
        return r;
    endfunction

    function automatic t_item make_item(t_cmd cmd, logic [31:0] src, logic [31:0] dst,
                                        logic [15:0] sport, logic [15:0] dport,
                                        logic [7:0] proto, logic [31:0] now);
        t_item it;
        it = '{cmd, src, dst, sport, dport, proto, now};
        return it;
    endfunction

    // Random value that leans toward the extremes now and then
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Command item with random payload; the block ignores it except on records
    function automatic t_item random_item(t_cmd cmd);
        t_item it;
        it = make_item(cmd, pick32(), pick32(), 16'(pick32()), 16'(pick32()),
                       8'(pick32()), pick32());
        return it;
    endfunction

    // Record of a known flow, a one-bit near miss of one, or a fresh flow
    function automatic t_item random_record();
        t_item it;
        t_row  key;
        int    sel;
        int    slot;
        it = random_item(CMD_RECORD);
        sel = $urandom_range(0, 99);
        if (flow_pool.size() != 0 && sel < 65) begin
            key = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            if (sel >= 50) begin
                case ($urandom_range(0, 4))
                    0:       key.src   ^= 32'd1 << $urandom_range(0, 31);
                    1:       key.dst   ^= 32'd1 << $urandom_range(0, 31);
                    2:       key.sport ^= 16'd1 << $urandom_range(0, 15);
                    3:       key.dport ^= 16'd1 << $urandom_range(0, 15);
                    default: key.proto ^= 8'd1 << $urandom_range(0, 7);
                endcase
            end
            it.src = key.src;
            it.dst = key.dst;
            it.sport = key.sport;
            it.dport = key.dport;
            it.proto = key.proto;
        end else begin
            key = '{it.src, it.dst, it.sport, it.dport, it.proto, '0, '0};
            if (flow_pool.size() < POOL_MAX) begin
                flow_pool.push_back(key);
            end else begin
                slot = $urandom_range(0, POOL_MAX - 1);
                flow_pool[slot] = key;
            end
        end
        return it;
    endfunction

    // Drive one item, hold it until taken, then idle between bursts
    task automatic send_item(input t_item it);
        start <= 1'b1;
        i_command <= it.cmd;
        i_src_addr <= it.src;
        i_dst_addr <= it.dst;
        i_src_port_in <= it.sport;
        i_dst_port_in <= it.dport;
        i_proto_in <= it.proto;
        i_now_seconds <= it.now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_replies.push_back(predict_flow_table(it));
        items_sent++;
        if (gaps_on && burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // Compare each reply with the oldest pending prediction
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n === 1'b1 && $isunknown(o_valid)) begin
            $error("o_valid unknown");
            error_count++;
        end else if (i_rst_n === 1'b1 && o_valid) begin
            if (expected_replies.size() == 0) begin
                $error("reply with no item pending: status %0d", o_status);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                replies_checked++;
                status_seen[want.status]++;
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("entry_total", 32'(want.total), 32'(o_entry_total));
                check_field("out_src_addr", want.row.src, o_out_src_addr);
                check_field("out_dst_addr", want.row.dst, o_out_dst_addr);
                check_field("out_src_port", 32'(want.row.sport), 32'(o_out_src_port));
                check_field("out_dst_port", 32'(want.row.dport), 32'(o_out_dst_port));
                check_field("out_proto", 32'(want.row.proto), 32'(o_out_proto));
                check_field("out_hits", want.row.hits, o_out_hits);
                check_field("out_time", want.row.stamp, o_out_time);
            end
        end
    end

    // Reader from reset, extreme tuples, near miss, read past the end, clear
    task automatic test_reader_basics();
        send_item(random_item(CMD_READ));
        send_item(random_item(CMD_READ));
        send_item(random_item(CMD_READ));
        send_item(make_item(CMD_RECORD, '0, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_RECORD, '1, '1, '1, '1, '1, '1));
        send_item(make_item(CMD_RECORD, '1, '1, '1, '1, '1, 32'd123));
        send_item(make_item(CMD_RECORD, '0, '0, '0, '0, 8'h01, 32'h8000_0000));
        send_item(random_item(CMD_READ));
        send_item(random_item(CMD_OPEN));
        repeat (5) send_item(random_item(CMD_READ));
        send_item(make_item(CMD_RECORD, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd443,
                            8'd6, 32'h1234_5678));
        send_item(random_item(CMD_READ));
        send_item(random_item(CMD_READ));
        send_item(random_item(CMD_CLEAR));
        send_item(random_item(CMD_READ));
        send_item(random_item(CMD_READ));
    endtask

    // Fill every row, drop on overflow, hit the first and last rows, read all back
    task automatic test_table_full();
        t_item first_flow;
        t_item last_flow;
        t_item it;
        send_item(random_item(CMD_CLEAR));
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            it = random_item(CMD_RECORD);
            it.dst = {it.dst[31:8], 8'(k)};
            if (k == 0) first_flow = it;
            last_flow = it;
            send_item(it);
        end
        it = random_item(CMD_RECORD);
        it.dst = {it.dst[31:8], 8'hFF};
        send_item(it);
        last_flow.now = $urandom();
        send_item(last_flow);
        first_flow.now = '1;
        send_item(first_flow);
        send_item(random_item(CMD_OPEN));
        repeat (TABLE_DEPTH + 3) send_item(random_item(CMD_READ));
        send_item(random_item(CMD_CLEAR));
    endtask

    // Mostly records over a shared flow pool, random reads and opens, rare clears
    task automatic test_random_traffic();
        int sel;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) gaps_on = ($urandom_range(0, 9) < 7);
            sel = $urandom_range(0, 999);
            if (sel < 600) begin
                send_item(random_record());
            end else if (sel < 880) begin
                send_item(random_item(CMD_READ));
            end else if (sel < 994) begin
                send_item(random_item(CMD_OPEN));
            end else begin
                send_item(random_item(CMD_CLEAR));
                flow_pool.delete();
            end
        end
    endtask

    initial begin
        error_count = 0;
        items_sent = 0;
        replies_checked = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        held_count = 0;
        read_pos = 0;
        size_done = 1'b0;
        burst_left = 0;
        gaps_on = 1'b1;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_command <= CMD_RECORD;
        i_src_addr <= '0;
        i_dst_addr <= '0;
        i_src_port_in <= '0;
        i_dst_port_in <= '0;
        i_proto_in <= '0;
        i_now_seconds <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reader_basics();
        gaps_on = 1'b0;
        test_table_full();
        gaps_on = 1'b1;
        test_table_full();
        test_random_traffic();

        // Drain outstanding replies, then watch for strays
        start <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items, checked %0d replies: %0d hits, %0d new flows, %0d drops,",
                 items_sent, replies_checked, status_seen[ST_HIT], status_seen[ST_NEW],
                 status_seen[ST_FULL]);
        $display("%0d size, %0d row, %0d empty, %0d end-of-log replies, %0d acks.",
                 status_seen[ST_SIZE], status_seen[ST_ROW], status_seen[ST_EMPTY],
                 status_seen[ST_EOL], status_seen[ST_ACK]);
        if (error_count == 0) begin
            $display("flow_log_table_top regression: pass");
        end else begin
            $display("flow_log_table_top regression: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("flow_log_table_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/flt_pkg.sv
hw/rtl/flt_ram.sv
hw/rtl/flt_upd.sv
hw/rtl/flow_log_table_top.sv
dv/flow_log_table_top_tb.sv
